[rtl/kta_pkg.sv]
`default_nettype none

package kta_pkg;

    localparam int ANG_FRAC = 16;
    localparam int COV_FRAC = 28;
    localparam int DT_FRAC  = 24;
    localparam int ADDR_W   = 4;

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_BOTH    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_START_ANGLE = 2'd0,
        REG_ANGLE_NOISE = 2'd1,
        REG_BIAS_NOISE  = 2'd2,
        REG_MEAS_NOISE  = 2'd3
    } t_reg;

    typedef struct packed {
        t_op                 operation;
        logic signed [31:0]  gyro_dps;
        logic        [23:0]  time_step;
        logic signed [31:0]  meas_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  angle_estimate;
        logic signed [31:0]  bias_estimate;
        logic                saturated;
    } t_out_item;

    typedef struct packed {
        logic                predict;
        logic                update;
        logic                restart;
        logic signed [31:0]  gyro;
        logic        [23:0]  dt;
        logic signed [31:0]  meas;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0]  start_angle;
        logic        [30:0]  apn;
        logic        [30:0]  bpn;
        logic        [30:0]  mn;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/kalman_tilt_angle_filter.sv]
// Throughput: one item at a time, a new item taken only once the last result is queued;
//   restart only reloads the state, predict runs four products on the shared multiplier,
//   update runs the serial divider for both gains and then six products, and both runs predict then update.
// Reset: synchronous, active low; clears queues, filter state and registers to their defaults.
`default_nettype none

module kalman_tilt_angle_filter #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire kta_pkg::t_in_item           i_item,
    output logic                             empty,
    input  wire logic                        pop,
    output kta_pkg::t_out_item               o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kta_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import kta_pkg::*;

    t_cfg        r_cfg;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        cmd_pop;
    t_out_item   res;
    logic        res_valid;
    logic        res_ready;
    t_out_item   r_oq [2];
    logic        r_owr;
    logic        r_ord;
    logic [1:0]  r_ocnt;
    logic        opush;
    logic        opop;
    t_reg        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg'(paddr[3:2]);

    always_comb begin
        case (reg_idx)
            REG_START_ANGLE: prdata = r_cfg.start_angle;
            REG_ANGLE_NOISE: prdata = {1'b0, r_cfg.apn};
            REG_BIAS_NOISE:  prdata = {1'b0, r_cfg.bpn};
            REG_MEAS_NOISE:  prdata = {1'b0, r_cfg.mn};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle <= '0;
            r_cfg.apn         <= 31'd268435;
            r_cfg.bpn         <= 31'd805306;
            r_cfg.mn          <= 31'd8053063;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_START_ANGLE: r_cfg.start_angle <= pwdata;
                REG_ANGLE_NOISE: r_cfg.apn         <= pwdata[30:0];
                REG_BIAS_NOISE:  r_cfg.bpn         <= pwdata[30:0];
                REG_MEAS_NOISE:  r_cfg.mn          <= pwdata[30:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    kta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    kta_back #(.W(WORD_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // result queue: hold finished results while the consumer stalls
    assign res_ready = (r_ocnt != 2'd2);
    assign empty     = (r_ocnt == 2'd0);
    assign o_result  = r_oq[r_ord];
    assign opush     = res_valid && res_ready;
    assign opop      = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush) begin
                r_owr <= ~r_owr;
            end
            if (opop) begin
                r_ord <= ~r_ord;
            end
            case ({opush, opop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_oq[r_owr] <= res;
        end
    end

endmodule

`default_nettype wire

[rtl/kta_front.sv]
`default_nettype none

module kta_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire kta_pkg::t_in_item i_item,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_pop,
    output kta_pkg::t_cmd       o_cmd
);
    import kta_pkg::*;

    t_cmd        r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    t_cmd        cmd;
    logic        push_ok;
    logic        pop_ok;

    // classify the operation code into the steps the back end runs
    always_comb begin
        cmd.restart = (i_item.operation == OP_RESTART);
        cmd.update  = (i_item.operation == OP_UPDATE) || (i_item.operation == OP_BOTH);
        cmd.predict = (i_item.operation == OP_PREDICT) || (i_item.operation == OP_BOTH);
        cmd.gyro    = i_item.gyro_dps;
        cmd.dt      = i_item.time_step;
        cmd.meas    = i_item.meas_angle;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/kta_mul.sv]
`default_nettype none

module kta_mul #(
    parameter int W   = 32,
    parameter int OPW = ((W > 32) ? W : 32) + 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [OPW-1:0] i_a,
    input  wire logic signed [OPW-1:0] i_b,
    input  wire logic                  i_frac28,
    output logic                       o_done,
    output logic signed [W-1:0]        o_res,
    output logic                       o_sat
);
    import kta_pkg::*;

    localparam int HW = (OPW + 1) / 2;
    localparam int AW = 4 * HW;
    localparam logic [AW-1:0] LIM = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND, M_FIN} t_mstate;

    t_mstate             r_state;
    logic [1:0]          r_idx;
    logic [2*HW-1:0]     r_ma;
    logic [2*HW-1:0]     r_mb;
    logic                r_neg;
    logic                r_sh28;
    logic [AW-1:0]       r_acc;
    logic                r_done;
    logic signed [W-1:0] r_res;
    logic                r_sat;

    logic [HW-1:0]       ah;
    logic [HW-1:0]       bh;
    logic [2*HW-1:0]     pp;
    logic [AW-1:0]       pp_sh;
    logic [AW-1:0]       shifted;
    logic                low;
    logic [AW-1:0]       lim;
    logic                big;
    logic [AW-1:0]       qsat;

    // one half-by-half partial product per cycle
    always_comb begin
        ah = r_idx[1] ? r_ma[2*HW-1:HW] : r_ma[HW-1:0];
        bh = r_idx[0] ? r_mb[2*HW-1:HW] : r_mb[HW-1:0];
        pp = {{HW{1'b0}}, ah} * {{HW{1'b0}}, bh};
        case ({r_idx[1] & r_idx[0], r_idx[1] ^ r_idx[0]})
            2'b00:   pp_sh = AW'(pp);
            2'b01:   pp_sh = AW'(pp) << HW;
            default: pp_sh = AW'(pp) << (2 * HW);
        endcase
        shifted = r_sh28 ? (r_acc >> COV_FRAC) : (r_acc >> DT_FRAC);
        low     = r_sh28 ? (|r_acc[COV_FRAC-1:0]) : (|r_acc[DT_FRAC-1:0]);
        lim     = LIM + AW'(r_neg);
        big     = (r_acc > lim);
        qsat    = big ? lim : r_acc;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_sat  = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_state <= M_ACC;
                    end
                end
                M_ACC: begin
                    if (r_idx == 2'd3) begin
                        r_state <= M_RND;
                    end
                end
                M_RND: r_state <= M_FIN;
                M_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
        case (r_state)
            M_IDLE: begin
                r_ma   <= (2*HW)'($unsigned(i_a[OPW-1] ? -i_a : i_a));
                r_mb   <= (2*HW)'($unsigned(i_b[OPW-1] ? -i_b : i_b));
                r_neg  <= i_a[OPW-1] ^ i_b[OPW-1];
                r_sh28 <= i_frac28;
                r_acc  <= '0;
                r_idx  <= 2'd0;
            end
            M_ACC: begin
                r_acc <= r_acc + pp_sh;
                r_idx <= r_idx + 2'd1;
            end
            // floor for negative products: bump the magnitude if bits were dropped
            M_RND: r_acc <= shifted + AW'(r_neg & low);
            M_FIN: begin
                r_res <= W'(r_neg ? -qsat : qsat);
                r_sat <= big;
            end
            default: r_acc <= r_acc;
        endcase
    end

endmodule

`default_nettype wire

[rtl/kta_div.sv]
`default_nettype none

module kta_div #(
    parameter int W = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [W-1:0] i_num0,
    input  wire logic signed [W-1:0] i_num1,
    input  wire logic signed [W-1:0] i_den,
    output logic                     o_done,
    output logic signed [W-1:0]      o_q0,
    output logic signed [W-1:0]      o_q1,
    output logic                     o_sat
);
    import kta_pkg::*;

    localparam int N  = W + COV_FRAC;
    localparam int CW = $clog2(N + 1);
    localparam logic [N-1:0] LIM = {{(N-W+1){1'b0}}, {(W-1){1'b1}}};

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate             r_state;
    logic [CW-1:0]       r_cnt;
    logic [N-1:0]        r_n0;
    logic [N-1:0]        r_n1;
    logic [W-1:0]        r_r0;
    logic [W-1:0]        r_r1;
    logic [N-1:0]        r_q0;
    logic [N-1:0]        r_q1;
    logic [W-1:0]        r_ud;
    logic                r_neg0;
    logic                r_neg1;
    logic                r_zero;
    logic                r_done;
    logic signed [W-1:0] r_res0;
    logic signed [W-1:0] r_res1;
    logic                r_sat;

    logic [W:0]          t0;
    logic [W:0]          t1;
    logic [W:0]          d0;
    logic [W:0]          d1;
    logic                ge0;
    logic                ge1;
    logic [N-1:0]        lim0;
    logic [N-1:0]        lim1;
    logic                big0;
    logic                big1;
    logic [N-1:0]        qs0;
    logic [N-1:0]        qs1;

    // restoring division, one quotient bit per cycle for both numerators
    always_comb begin
        t0   = {r_r0, r_n0[N-1]};
        t1   = {r_r1, r_n1[N-1]};
        d0   = t0 - {1'b0, r_ud};
        d1   = t1 - {1'b0, r_ud};
        ge0  = (t0 >= {1'b0, r_ud});
        ge1  = (t1 >= {1'b0, r_ud});
        lim0 = LIM + N'(r_neg0);
        lim1 = LIM + N'(r_neg1);
        big0 = (r_q0 > lim0);
        big1 = (r_q1 > lim1);
        qs0  = big0 ? lim0 : r_q0;
        qs1  = big1 ? lim1 : r_q1;
    end

    assign o_done = r_done;
    assign o_q0   = r_res0;
    assign o_q1   = r_res1;
    assign o_sat  = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_den == '0) ? D_FIN : D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == CW'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
        case (r_state)
            D_IDLE: begin
                r_zero <= (i_den == '0);
                r_ud   <= $unsigned(i_den[W-1] ? -i_den : i_den);
                r_n0   <= {$unsigned(i_num0[W-1] ? -i_num0 : i_num0), {COV_FRAC{1'b0}}};
                r_n1   <= {$unsigned(i_num1[W-1] ? -i_num1 : i_num1), {COV_FRAC{1'b0}}};
                r_neg0 <= i_num0[W-1] ^ i_den[W-1];
                r_neg1 <= i_num1[W-1] ^ i_den[W-1];
                r_r0   <= '0;
                r_r1   <= '0;
                r_cnt  <= CW'(N);
            end
            D_RUN: begin
                r_n0  <= r_n0 << 1;
                r_n1  <= r_n1 << 1;
                r_r0  <= ge0 ? d0[W-1:0] : t0[W-1:0];
                r_r1  <= ge1 ? d1[W-1:0] : t1[W-1:0];
                r_q0  <= {r_q0[N-2:0], ge0};
                r_q1  <= {r_q1[N-2:0], ge1};
                r_cnt <= r_cnt - CW'(1);
            end
            D_FIN: begin
                // zero divisor gives zero gains without saturation
                r_res0 <= r_zero ? '0 : W'(r_neg0 ? -qs0 : qs0);
                r_res1 <= r_zero ? '0 : W'(r_neg1 ? -qs1 : qs1);
                r_sat  <= !r_zero && (big0 || big1);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule

`default_nettype wire

[rtl/kta_back.sv]
`default_nettype none

module kta_back #(
    parameter int W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    output logic                  o_cmd_pop,
    input  wire kta_pkg::t_cmd    i_cmd,
    input  wire kta_pkg::t_cfg    i_cfg,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output kta_pkg::t_out_item    o_res
);
    import kta_pkg::*;

    localparam int OW  = (W > 32) ? W : 32;
    localparam int OPW = OW + 1;
    localparam int SW  = OW + 2;
    localparam logic signed [SW-1:0] HI   = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] LO   = -HI - SW'(1);
    localparam logic signed [SW-1:0] HI32 = SW'(33'sh0_7FFF_FFFF);
    localparam logic signed [SW-1:0] LO32 = -HI32 - SW'(1);
    localparam logic signed [SW-1:0] HALF = SW'(180) <<< ANG_FRAC;
    localparam logic signed [SW-1:0] FULL = SW'(360) <<< ANG_FRAC;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PRED, ST_MUL, ST_MWAIT, ST_UPD, ST_DWAIT, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        STEP_DTP11, STEP_ANGLE, STEP_P00, STEP_P11,
        STEP_K0Y, STEP_K1Y, STEP_K0P00, STEP_K0P01, STEP_K1P00, STEP_K1P01
    } t_step;

    typedef struct packed {
        logic                ovf;
        logic signed [W-1:0] val;
    } t_satw;

    typedef struct packed {
        logic                ovf;
        logic signed [31:0]  val;
    } t_sat32;

    function automatic t_satw sat_w(input logic signed [SW-1:0] v);
        t_satw s;
        s.ovf = 1'b0;
        s.val = v[W-1:0];
        if (v > HI) begin
            s.ovf = 1'b1;
            s.val = HI[W-1:0];
        end else if (v < LO) begin
            s.ovf = 1'b1;
            s.val = LO[W-1:0];
        end
        return s;
    endfunction

    function automatic t_sat32 sat_32(input logic signed [SW-1:0] v);
        t_sat32 s;
        s.ovf = 1'b0;
        s.val = v[31:0];
        if (v > HI32) begin
            s.ovf = 1'b1;
            s.val = HI32[31:0];
        end else if (v < LO32) begin
            s.ovf = 1'b1;
            s.val = LO32[31:0];
        end
        return s;
    endfunction

    function automatic logic signed [SW-1:0] ext(input logic signed [W-1:0] x);
        return SW'(x);
    endfunction

    t_state              r_state, n_state;
    t_step               r_step, n_step;
    t_cmd                r_cmd, n_cmd;
    logic signed [W-1:0] r_angle, n_angle;
    logic signed [W-1:0] r_bias, n_bias;
    logic signed [W-1:0] r_p00, n_p00;
    logic signed [W-1:0] r_p01, n_p01;
    logic signed [W-1:0] r_p10, n_p10;
    logic signed [W-1:0] r_p11, n_p11;
    logic signed [W-1:0] r_rate, n_rate;
    logic signed [W-1:0] r_dtp11, n_dtp11;
    logic signed [W-1:0] r_t, n_t;
    logic signed [W-1:0] r_y, n_y;
    logic signed [W-1:0] r_k0, n_k0;
    logic signed [W-1:0] r_k1, n_k1;
    logic signed [W-1:0] r_p00o, n_p00o;
    logic signed [W-1:0] r_p01o, n_p01o;
    logic                r_sat, n_sat;

    logic                  mul_start;
    logic signed [OPW-1:0] mul_a;
    logic signed [OPW-1:0] mul_b;
    logic                  mul_frac28;
    logic                  mul_done;
    logic signed [W-1:0]   mul_res;
    logic                  mul_sat;
    logic                  div_start;
    logic signed [W-1:0]   div_den;
    logic                  div_done;
    logic signed [W-1:0]   div_q0;
    logic signed [W-1:0]   div_q1;
    logic                  div_sat;
    logic signed [OPW-1:0] dt_op;
    t_sat32                ca;
    t_sat32                cb;
    t_satw                 den_s;

    kta_mul #(.W(W), .OPW(OPW)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_frac28 (mul_frac28),
        .o_done   (mul_done),
        .o_res    (mul_res),
        .o_sat    (mul_sat)
    );

    kta_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num0  (r_p00),
        .i_num1  (r_p10),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q0    (div_q0),
        .o_q1    (div_q1),
        .o_sat   (div_sat)
    );

    // operands of the shared multiplier for each step
    always_comb begin
        dt_op      = OPW'(r_cmd.dt);
        mul_frac28 = 1'b1;
        case (r_step)
            STEP_DTP11: begin mul_a = dt_op; mul_b = OPW'(r_p11); mul_frac28 = 1'b0; end
            STEP_ANGLE: begin mul_a = OPW'(r_rate); mul_b = dt_op; mul_frac28 = 1'b0; end
            STEP_P00:   begin mul_a = dt_op; mul_b = OPW'(r_t); mul_frac28 = 1'b0; end
            STEP_P11:   begin mul_a = OPW'(i_cfg.bpn); mul_b = dt_op; mul_frac28 = 1'b0; end
            STEP_K0Y:   begin mul_a = OPW'(r_k0); mul_b = OPW'(r_y); end
            STEP_K1Y:   begin mul_a = OPW'(r_k1); mul_b = OPW'(r_y); end
            STEP_K0P00: begin mul_a = OPW'(r_k0); mul_b = OPW'(r_p00o); end
            STEP_K0P01: begin mul_a = OPW'(r_k0); mul_b = OPW'(r_p01o); end
            STEP_K1P00: begin mul_a = OPW'(r_k1); mul_b = OPW'(r_p00o); end
            STEP_K1P01: begin mul_a = OPW'(r_k1); mul_b = OPW'(r_p01o); end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        t_satw s1, s2, s3, s4;
        logic signed [SW-1:0] m_ext;
        logic signed [SW-1:0] diff;
        n_state = r_state;
        n_step  = r_step;
        n_cmd   = r_cmd;
        n_angle = r_angle;
        n_bias  = r_bias;
        n_p00   = r_p00;
        n_p01   = r_p01;
        n_p10   = r_p10;
        n_p11   = r_p11;
        n_rate  = r_rate;
        n_dtp11 = r_dtp11;
        n_t     = r_t;
        n_y     = r_y;
        n_k0    = r_k0;
        n_k1    = r_k1;
        n_p00o  = r_p00o;
        n_p01o  = r_p01o;
        n_sat   = r_sat;
        o_cmd_pop   = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        o_res_valid = 1'b0;
        s1 = '0;
        s2 = '0;
        s3 = '0;
        s4 = '0;
        m_ext = ext(mul_res);
        diff  = SW'(r_cmd.meas) - ext(r_angle);
        if (diff > HALF) begin
            diff = diff - FULL;
        end
        if (diff < -HALF) begin
            diff = diff + FULL;
        end
        den_s   = sat_w(ext(r_p00) + SW'(i_cfg.mn));
        div_den = den_s.val;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_sat     = 1'b0;
                    if (i_cmd.restart) begin
                        s1      = sat_w(SW'(i_cfg.start_angle));
                        n_angle = s1.val;
                        n_sat   = s1.ovf;
                        n_bias  = '0;
                        n_p00   = '0;
                        n_p01   = '0;
                        n_p10   = '0;
                        n_p11   = '0;
                        n_state = ST_OUT;
                    end else if (i_cmd.predict) begin
                        n_state = ST_PRED;
                    end else begin
                        n_state = ST_UPD;
                    end
                end
            end
            ST_PRED: begin
                s1      = sat_w(SW'(r_cmd.gyro) - ext(r_bias));
                n_rate  = s1.val;
                n_sat   = r_sat | s1.ovf;
                n_step  = STEP_DTP11;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                mul_start = 1'b1;
                n_state   = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    case (r_step)
                        STEP_DTP11: begin
                            n_dtp11 = mul_res;
                            s1  = sat_w(m_ext - ext(r_p01));
                            s2  = sat_w(ext(s1.val) - ext(r_p10));
                            n_t = s2.val;
                        end
                        STEP_ANGLE: begin
                            s1      = sat_w(ext(r_angle) + m_ext);
                            n_angle = s1.val;
                        end
                        STEP_P00: begin
                            s1    = sat_w(ext(r_p00) + m_ext);
                            s2    = sat_w(ext(s1.val) + SW'(i_cfg.apn));
                            s3    = sat_w(ext(r_p01) - ext(r_dtp11));
                            s4    = sat_w(ext(r_p10) - ext(r_dtp11));
                            n_p00 = s2.val;
                            n_p01 = s3.val;
                            n_p10 = s4.val;
                        end
                        STEP_P11: begin
                            s1    = sat_w(ext(r_p11) + m_ext);
                            n_p11 = s1.val;
                        end
                        STEP_K0Y: begin
                            s1      = sat_w(ext(r_angle) + m_ext);
                            n_angle = s1.val;
                        end
                        STEP_K1Y: begin
                            s1     = sat_w(ext(r_bias) + m_ext);
                            n_bias = s1.val;
                        end
                        STEP_K0P00: begin
                            s1    = sat_w(ext(r_p00) - m_ext);
                            n_p00 = s1.val;
                        end
                        STEP_K0P01: begin
                            s1    = sat_w(ext(r_p01) - m_ext);
                            n_p01 = s1.val;
                        end
                        STEP_K1P00: begin
                            s1    = sat_w(ext(r_p10) - m_ext);
                            n_p10 = s1.val;
                        end
                        STEP_K1P01: begin
                            s1    = sat_w(ext(r_p11) - m_ext);
                            n_p11 = s1.val;
                        end
                        default: s1 = '0;
                    endcase
                    n_sat = r_sat | mul_sat | s1.ovf | s2.ovf | s3.ovf | s4.ovf;
                    if (r_step == STEP_P11) begin
                        n_state = r_cmd.update ? ST_UPD : ST_OUT;
                    end else if (r_step == STEP_K1P01) begin
                        n_state = ST_OUT;
                    end else begin
                        n_step  = t_step'(r_step + 4'd1);
                        n_state = ST_MUL;
                    end
                end
            end
            ST_UPD: begin
                // innovation wrapped once into the half turn, gains start from S
                s1        = sat_w(diff);
                s2        = sat_w(ext(r_p00) + SW'(i_cfg.mn));
                n_y       = s1.val;
                n_p00o    = r_p00;
                n_p01o    = r_p01;
                n_sat     = r_sat | s1.ovf | s2.ovf;
                div_start = 1'b1;
                n_state   = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    n_k0    = div_q0;
                    n_k1    = div_q1;
                    n_sat   = r_sat | div_sat;
                    n_step  = STEP_K0Y;
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ca = sat_32(ext(r_angle));
        cb = sat_32(ext(r_bias));
        o_res.angle_estimate = ca.val;
        o_res.bias_estimate  = cb.val;
        o_res.saturated      = r_sat | ca.ovf | cb.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= '0;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= '0;
        end else begin
            r_state <= n_state;
            r_angle <= n_angle;
            r_bias  <= n_bias;
            r_p00   <= n_p00;
            r_p01   <= n_p01;
            r_p10   <= n_p10;
            r_p11   <= n_p11;
        end
        r_step  <= n_step;
        r_cmd   <= n_cmd;
        r_rate  <= n_rate;
        r_dtp11 <= n_dtp11;
        r_t     <= n_t;
        r_y     <= n_y;
        r_k0    <= n_k0;
        r_k1    <= n_k1;
        r_p00o  <= n_p00o;
        r_p01o  <= n_p01o;
        r_sat   <= n_sat;
    end

endmodule

`default_nettype wire

[rtl/kta_checker.sv]
`default_nettype none

module kta_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               push,
    input wire logic               full,
    input wire logic               pop,
    input wire logic               empty,
    input wire logic               pready,
    input wire kta_pkg::t_out_item o_result
);
    import kta_pkg::*;

    logic [2:0] r_outstanding;

    // count transfers accepted but not yet popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= 3'd0;
        end else begin
            case ({push && !full, pop && !empty})
                2'b10:   r_outstanding <= r_outstanding + 3'd1;
                2'b01:   r_outstanding <= r_outstanding - 3'd1;
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding == 3'd0) |-> empty)
        else $error("result shown with no transfer outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding <= 3'd5))
        else $error("more transfers accepted than the block can hold");

endmodule

bind kalman_tilt_angle_filter kta_checker u_kta_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pready   (pready),
    .o_result (o_result)
);

`default_nettype wire
